>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clock and reset named at the call site.
`define BSA_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Common case: clk / rst_n in scope.
`define BSA_ASSERT(label, prop, msg) \
    `BSA_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

>>> design/bsa_pkg.sv
package bsa_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int CFG_W         = 9;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 9'd256;

    // command codes
    localparam logic [1:0] ACT_TAKE   = 2'd0;
    localparam logic [1:0] ACT_RETURN = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // word scan result
    typedef struct packed {
        logic       found;
        logic [2:0] bit_idx;
    } scan_t;

endpackage

>>> design/bitmap_slot_allocator.sv
// Bitmap first-free slot allocator.
// Command channel: action / return_index are taken at a clock edge where
// start is high and busy is low. One result per command appears on
// slot_index / status for exactly one cycle with done high; the receiver
// cannot hold it off, so no stall exists on the result side.
// Capacity: cfg_wr_en / cfg_wr_data write capacity_reg (applied limited to
// SLOTS); write it only while the block is idle.
// Steps per command, from the accepting edge to the done cycle:
//   take   : bitmap words are examined in order from word 0, 1..SLOTS/8 of
//            them; one word per cycle through the word scan unit fed by the
//            registered memory read port.
//   return : read-modify-write of one word; skipped if out of range.
//   clear  : every word written to zero, one word written per cycle.
//   code 3 : no operation.
// One command at a time: busy is high from the accepting edge until the done
// cycle, where it drops; out-of-range returns and code 3 never raise it.
// Reset: capacity returns to 256 and a clearing pass writes every bitmap
// word to zero with busy high; no result is produced for it.
module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       action,
    input  logic [7:0]       return_index,
    output logic             done,
    output logic [7:0]       slot_index,
    output logic [1:0]       status,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int WORDS = (SLOTS + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CAP_W = $clog2(SLOTS + 1);
    localparam int CMP_W = ((CAP_W > CFG_W) ? CAP_W : CFG_W) + 1;
    localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);
    localparam logic [CMP_W-1:0] SLOTS_C   = CMP_W'(SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_CLEAR = 5'b00100,
        ST_TSCAN = 5'b01000,
        ST_RMOD  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     word_reg, word_next;
    logic [7:0]        ridx_reg, ridx_next;
    logic [CFG_W-1:0]  capacity_reg;
    logic              done_reg, done_next;
    logic [7:0]        slot_reg, slot_next;
    logic [1:0]        status_reg, status_next;

    // bitmap memory, one word per 8 slots
    logic [7:0]        mem [WORDS];
    logic [7:0]        rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    logic [CMP_W-1:0]  cfg_ext;
    logic [CMP_W-1:0]  eff_cap;
    logic [CMP_W-1:0]  base;
    logic [CMP_W-1:0]  next_base;
    logic [CMP_W-1:0]  slot_full;
    scan_t             scan;

    // capacity saturates at the pool size
    assign cfg_ext   = CMP_W'(capacity_reg);
    assign eff_cap   = (cfg_ext > SLOTS_C) ? SLOTS_C : cfg_ext;
    assign base      = CMP_W'({word_reg, 3'b000});
    assign next_base = base + CMP_W'(8);
    assign slot_full = CMP_W'({word_reg, scan.bit_idx});

    bsa_word_scan #(
        .CMP_W(CMP_W)
    ) u_scan (
        .word_data(rd_data_reg),
        .base     (base),
        .cap      (eff_cap),
        .result   (scan)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        ridx_next   = ridx_reg;
        done_next   = 1'b0;
        slot_next   = slot_reg;
        status_next = status_reg;
        rd_addr     = word_reg;
        wr_en       = 1'b0;
        wr_addr     = word_reg;
        wr_data     = 8'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_TAKE:
                        begin
                            rd_addr    = '0;
                            word_next  = '0;
                            state_next = ST_TSCAN;
                        end
                        ACT_RETURN:
                        begin
                            ridx_next = return_index;
                            if (CMP_W'(return_index) >= eff_cap)
                            begin
                                done_next   = 1'b1;
                                slot_next   = return_index;
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                rd_addr    = AW'(return_index >> 3);
                                word_next  = AW'(return_index >> 3);
                                state_next = ST_RMOD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            word_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            slot_next   = 8'd0;
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_INIT, ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (word_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                    if (state_reg == ST_CLEAR)
                    begin
                        done_next   = 1'b1;
                        slot_next   = 8'd0;
                        status_next = STAT_OK;
                    end
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end
            ST_TSCAN:
            begin
                if (scan.found)
                begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data_reg | (8'h80 >> scan.bit_idx);
                    done_next   = 1'b1;
                    slot_next   = slot_full[7:0];
                    status_next = STAT_OK;
                    state_next  = ST_IDLE;
                end
                else if (next_base >= eff_cap)
                begin
                    done_next   = 1'b1;
                    slot_next   = 8'd0;
                    status_next = STAT_FULL;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // fetch next word while this one is rejected
                    word_next = word_reg + AW'(1);
                    rd_addr   = word_reg + AW'(1);
                end
            end
            ST_RMOD:
            begin
                wr_en       = 1'b1;
                wr_data     = rd_data_reg & ~(8'h80 >> ridx_reg[2:0]);
                done_next   = 1'b1;
                slot_next   = ridx_reg;
                status_next = STAT_OK;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            word_reg     <= '0;
            done_reg     <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ridx_reg   <= ridx_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign slot_index = slot_reg;
    assign status     = status_reg;

endmodule

>>> design/bsa_word_scan.sv
// Finds the lowest free slot in one bitmap word (MSB = lowest slot),
// limited to slots below the capacity.
module bsa_word_scan
    import bsa_pkg::*;
#(
    parameter int CMP_W = 10
)
(
    input  logic [7:0]       word_data,
    input  logic [CMP_W-1:0] base,
    input  logic [CMP_W-1:0] cap,
    output scan_t            result
);

    logic [CMP_W-1:0] diff;
    logic [3:0]       limit;
    logic [7:0]       free;

    always_comb
    begin
        diff = cap - base;
        if (cap <= base)
        begin
            limit = 4'd0;
        end
        else if (diff >= CMP_W'(8))
        begin
            limit = 4'd8;
        end
        else
        begin
            limit = diff[3:0];
        end
        for (int b = 0; b < 8; b++)
        begin
            free[b] = !word_data[7-b] && (4'(b) < limit);
        end
        result.found   = |free;
        result.bit_idx = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (free[b])
            begin
                result.bit_idx = 3'(b);
            end
        end
    end

endmodule

>>> design/bsa_checker.sv
`include "assert_macros.svh"

module bsa_checker
    import bsa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       action,
    input logic [7:0]       return_index,
    input logic             done,
    input logic [7:0]       slot_index,
    input logic [1:0]       status
);

    logic ret_xfer;
    logic full_res;
    logic range_res;

    assign ret_xfer  = start && !busy && (action == ACT_RETURN);
    assign full_res  = done && (status == STAT_FULL);
    assign range_res = done && (status == STAT_RANGE);

    `BSA_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "command lost")
    `BSA_ASSERT(a_done_not_busy, done |-> !busy, "result shown while still busy")
    `BSA_ASSERT(a_full_zero_index, full_res |-> (slot_index == 8'd0), "full with nonzero index")
    `BSA_ASSERT(a_range_only_return, range_res |-> $past(ret_xfer), "range flag without return")
    `BSA_ASSERT(a_range_echo, range_res |-> (slot_index == $past(return_index)), "range echo")

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

>>> verif/testbench.sv
// Bitmap allocator check: a local pool model predicts slot_index / status for
// every command at the edge where it is accepted, and the checker compares
// each done cycle against the oldest prediction.
module testbench;
    import bsa_pkg::*;

    localparam int SLOTS      = 256;
    localparam int WORDS      = SLOTS / 8;
    localparam int STALL_MAX  = 3000;   // cycles with no transfer before giving up
    localparam int TAIL       = 40;     // settle time after the last result
    localparam int ITEM_GOAL  = 1800;

    // unused command code, behaves as a no-op
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [7:0] slot;
        logic [1:0] status;
    } grant_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       action = ACT_TAKE;
    logic [7:0]       return_index = 8'd0;
    logic             done;
    logic [7:0]       slot_index;
    logic [1:0]       status;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    // local copy of the occupancy bitmap and capacity register
    logic [7:0]       pool_words [WORDS];
    logic [CFG_W-1:0] capacity_reg;

    // predicted grants, oldest first
    grant_t pending_grants [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;

    int n_sent = 0, n_take = 0, n_return = 0, n_clear = 0, n_nop = 0;
    int n_full = 0, n_range = 0, n_cfg = 0;

    bitmap_slot_allocator #(.SLOTS(SLOTS)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .return_index (return_index),
        .done         (done),
        .slot_index   (slot_index),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // capacity as the block applies it: saturates at the pool size
    function automatic int eff_capacity();
        return (int'(capacity_reg) > SLOTS) ? SLOTS : int'(capacity_reg);
    endfunction

    // predicted result per command; takes do a first-free search, MSB of each word is the lowest slot
    function automatic grant_t compute_grant(input logic [1:0] act, input logic [7:0] idx);
        grant_t     g;
        int         cap;
        logic [7:0] mask;
        g.slot   = 8'd0;
        g.status = STAT_OK;
        cap      = eff_capacity();
        case (act)
            ACT_TAKE:
            begin
                g.status = STAT_FULL;
                for (int s = 0; s < cap; s++)
                begin
                    mask = 8'h80 >> (s % 8);
                    if ((pool_words[s / 8] & mask) == 8'd0)
                    begin
                        pool_words[s / 8] = pool_words[s / 8] | mask;
                        g.slot   = 8'(s);
                        g.status = STAT_OK;
                        break;
                    end
                end
            end
            ACT_RETURN:
            begin
                g.slot = idx;
                // out-of-range return leaves the bitmap alone, even if the bit is set
                if (int'(idx) >= cap)
                    g.status = STAT_RANGE;
                else
                    pool_words[idx[7:3]] = pool_words[idx[7:3]] & ~(8'h80 >> idx[2:0]);
            end
            ACT_CLEAR:
            begin
                foreach (pool_words[w])
                    pool_words[w] = 8'd0;
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    // One command transfer. A new burst opens with a gap if gaps_on is set; items
    // inside a burst go back to back with start held high across the accepting edge.
    task automatic send(input logic [1:0] act, input logic [7:0] idx);
        int     gap;
        grant_t g;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        return_index <= idx;
        // busy is sampled before the edge updates, so this is the accepting edge
        do @(posedge clk); while (busy);
        g = compute_grant(act, idx);
        pending_grants.push_back(g);
        n_sent++;
        case (act)
            ACT_TAKE:   n_take++;
            ACT_RETURN: n_return++;
            ACT_CLEAR:  n_clear++;
            default:    n_nop++;
        endcase
        if (g.status == STAT_FULL)
            n_full++;
        if (g.status == STAT_RANGE)
            n_range++;
    endtask

    // hold off until every predicted result has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_grants.size() != 0 || busy);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        capacity_reg  = value;
        n_cfg++;
    endtask

    // Random commands. Return indexes lean toward the live range so holes open
    // up inside the used area; the rest hit the whole field and the cap edge.
    task automatic random_items(input int n, input int take_pct, input int ret_pct,
                                input int clear_pct);
        int         p;
        int         cap;
        int         pick;
        logic [1:0] act;
        logic [7:0] idx;
        repeat (n)
        begin
            cap  = eff_capacity();
            p    = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (p < take_pct)
                act = ACT_TAKE;
            else if (p < take_pct + ret_pct)
                act = ACT_RETURN;
            else if (p < take_pct + ret_pct + clear_pct)
                act = ACT_CLEAR;
            else
                act = ACT_NOP;
            if (pick < 60 && cap > 0)
                idx = 8'($urandom_range(0, cap - 1));
            else if (pick < 80 || cap == 0)
                idx = 8'($urandom_range(0, 255));
            else
            begin
                pick = cap - 1 + $urandom_range(0, 2);
                idx  = (pick > 255) ? 8'd255 : 8'(pick);
            end
            send(act, idx);
        end
    endtask

    // --- tests ---

    // Reset capacity is the full pool; takes hand out slots from zero upward.
    task automatic test_reset_state();
        send(ACT_TAKE, 8'd0);
        send(ACT_TAKE, 8'd255);
        send(ACT_TAKE, 8'd0);
        send(ACT_RETURN, 8'd1);
        send(ACT_TAKE, 8'd0);        // refills the hole at slot 1
        send(ACT_RETURN, 8'd255);    // top slot, already free
        send(ACT_NOP, 8'd255);       // unused code: zero slot, ok status
    endtask

    // Capacity edge cases, full pool, out-of-range returns, lowered capacity.
    task automatic test_capacity_corners();
        write_capacity(9'd1);
        send(ACT_TAKE, 8'd0);        // slot 0 still held: pool full
        send(ACT_RETURN, 8'd0);
        send(ACT_TAKE, 8'd0);
        send(ACT_TAKE, 8'd0);
        send(ACT_RETURN, 8'd1);      // at capacity: range error
        write_capacity(9'd0);
        send(ACT_TAKE, 8'd0);        // nothing may be allocated
        send(ACT_RETURN, 8'd0);
        send(ACT_CLEAR, 8'd170);
        write_capacity(9'd300);      // saturates to the pool size
        repeat (6) send(ACT_TAKE, 8'd85);
        write_capacity(9'd3);        // slots 3..5 stay set above the new cap
        send(ACT_RETURN, 8'd5);
        send(ACT_TAKE, 8'd0);
        send(ACT_CLEAR, 8'd0);
        send(ACT_TAKE, 8'd0);
        write_capacity(9'd511);
        send(ACT_RETURN, 8'd255);
        send(ACT_NOP, 8'd0);
    endtask

    // Fill the whole pool back to back, so takes walk all 32 words.
    task automatic test_fill_pool();
        write_capacity(9'd256);
        gaps_on = 1'b0;
        random_items(300, 92, 8, 0);
        send(ACT_TAKE, 8'd0);
        random_items(60, 40, 60, 0);
        gaps_on = 1'b1;
        send(ACT_CLEAR, 8'd255);
    endtask

    // Walk a set of capacities, extremes included, with a mixed command stream.
    task automatic test_capacity_sweep();
        logic [CFG_W-1:0] caps [10];
        caps = '{9'd8, 9'd9, 9'd1, 9'd0, 9'd255, 9'd37, 9'd511, 9'd300, 9'd16, 9'd256};
        foreach (caps[i])
        begin
            write_capacity(caps[i]);
            gaps_on = (i % 3 != 2);
            random_items(90, 58, 36, 3);
        end
        gaps_on = 1'b1;
    endtask

    // Random capacities until the item budget is spent; mostly small pools so
    // they fill and drain often, now and then a wide one.
    task automatic test_random_mix();
        int               n;
        logic [CFG_W-1:0] cap;
        while (n_sent < ITEM_GOAL)
        begin
            cap = ($urandom_range(0, 9) < 6) ? 9'($urandom_range(0, 40))
                                              : 9'($urandom_range(0, 511));
            write_capacity(cap);
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(30, 120);
            random_items(n, $urandom_range(40, 70), 26, $urandom_range(0, 4));
            if ($urandom_range(0, 4) == 0)
                drain();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        foreach (pool_words[w])
            pool_words[w] = 8'd0;
        capacity_reg = CAPACITY_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_capacity_corners();
        test_fill_pool();
        test_capacity_sweep();
        test_random_mix();

        drain();
        repeat (TAIL) @(posedge clk);
        $display("Covered %0d commands: %0d take, %0d return, %0d clear, %0d no-op.",
                 n_sent, n_take, n_return, n_clear, n_nop);
        $display("Seen %0d pool-full, %0d out-of-range results over %0d capacity writes.",
                 n_full, n_range, n_cfg);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result checker: done is high for exactly one cycle per command.
    always @(posedge clk)
    begin : check_results
        grant_t want;
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result slot_index %0d status %0d",
                         $time, slot_index, status);
                mismatches++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (slot_index !== want.slot)
                begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, slot_index);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any command or result transfer restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_MAX, pending_grants.size());
            $display("FAIL");
            $finish;
        end
    end

endmodule
